/* rtl/tdqd_pkg.sv */
// ----------------------------------------------------------------------------
// tdqd_pkg
// Shared types and constants for the tail drain / quiet detector.
// ----------------------------------------------------------------------------
package tdqd_pkg;

   localparam int FRAMES_W = 16;
   localparam int PEAK_W   = 24;
   localparam int POS_W    = 63;
   localparam int DRAIN_W  = 32;
   localparam int LEFT_W   = 34;
   localparam int SILENT_W = 32;
   localparam int BUFF_W   = 14;
   localparam int RATE_W   = 19;
   localparam int THR_W    = 24;
   localparam int NEED_W   = RATE_W - 2;
   localparam int STEP_W   = $clog2(DRAIN_W);

   localparam int REQ_DATA_W = 144;
   localparam int RSP_DATA_W = 72;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 24;

   localparam int QUEUE_DEPTH = 2;

   localparam logic [BUFF_W-1:0] BUFFER_FRAMES_RST     = BUFF_W'(512);
   localparam logic [RATE_W-1:0] SAMPLE_RATE_RST       = RATE_W'(48000);
   localparam logic [THR_W-1:0]  SILENCE_THRESHOLD_RST = THR_W'(7);

   typedef enum logic [1:0] {
      MODE_BLOCK = 2'd0,
      MODE_START = 2'd1,
      MODE_STOP  = 2'd2,
      MODE_HOLD  = 2'd3
   } mode_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_BUFFER_FRAMES     = 2'd0,
      CSR_SAMPLE_RATE       = 2'd1,
      CSR_SILENCE_THRESHOLD = 2'd2
   } csr_index_type;

   // one classified request as it sits in the queue
   typedef struct packed {
      mode_type            mode;
      logic                drain_pos;   // drain request is above zero
      logic [FRAMES_W-1:0] frame_count;
      logic [PEAK_W-1:0]   peak_level;
      logic                peak_not_finite;
      logic                playing;
      logic [POS_W-1:0]    play_position;
      logic [DRAIN_W-1:0]  drain_frames;
   } entry_type;

   typedef struct packed {
      logic push;
      logic full;
   } qctl_type;

endpackage

/* rtl/tail_drain_quiet_detector.sv */
// ----------------------------------------------------------------------------
// tail_drain_quiet_detector
// Tail drain tracking and quiet detection for a stopped audio transport.
// ----------------------------------------------------------------------------
//  channel | dir | ports                           | content
//  --------+-----+---------------------------------+---------------------------
//  req     | in  | req_tvalid/tready/tdata/tuser   | one command or audio block
//  rsp     | out | rsp_tvalid/tready/tdata         | one status per request
//  csr     | in  | csr_we/index/wdata              | register writes
//
//  Audio, start, hold and non-draining stop requests pass from the queue slot to
//  the back's work register, then set the response register in the execute state.
//  A stop request with a positive drain first passes through the remainder unit,
//  which rounds the drain one numerator bit per cycle.
//  The queue takes requests while the back is busy or the response is stalled.
//  Reset is synchronous; registers return to 512 / 48000 / 7.
// ----------------------------------------------------------------------------
module tail_drain_quiet_detector #(
   parameter int QueueDepth = tdqd_pkg::QUEUE_DEPTH
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // frame_count[15:0], peak_level[39:16], peak_not_finite[40], playing[41],
   // play_position[104:42], drain_frames[136:105]
   input  logic [tdqd_pkg::REQ_DATA_W-1:0]    req_tdata,
   // mode[1:0]
   input  logic [1:0]                         req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // transport_quiet[0], quiet_event[1], drain_busy[2], mute_output[3],
   // render_position[66:4]
   output logic [tdqd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input  logic                               csr_we,
   input  logic [tdqd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdqd_pkg::CSR_DATA_W-1:0]    csr_wdata
);
   import tdqd_pkg::*;

   qctl_type  qctl;
   entry_type push_entry;
   entry_type head_entry;
   logic      q_full;
   logic      q_pop;
   logic      head_valid;

   tdqd_front u_front (
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .qctl_push  (qctl),
      .q_full     (q_full),
      .q_entry    (push_entry)
   );

   tdqd_queue #(
      .Depth (QueueDepth)
   ) u_queue (
      .clock      (clock),
      .reset      (reset),
      .qctl_push  (qctl),
      .push_entry (push_entry),
      .full       (q_full),
      .pop        (q_pop),
      .head_valid (head_valid),
      .head_entry (head_entry)
   );

   tdqd_back u_back (
      .clock      (clock),
      .reset      (reset),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .q_valid    (head_valid),
      .q_entry    (head_entry),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

/* rtl/tdqd_front.sv */
// ----------------------------------------------------------------------------
// tdqd_front
// Request intake: unpacks the request, classifies it and pushes it to the queue.
// ----------------------------------------------------------------------------
module tdqd_front (
   input  logic                               req_tvalid,
   output logic                               req_tready,
   input  logic [tdqd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input  logic [1:0]                         req_tuser,
   output tdqd_pkg::qctl_type                 qctl_push,
   input  logic                               q_full,
   output tdqd_pkg::entry_type                q_entry
);
   import tdqd_pkg::*;

   logic [DRAIN_W-1:0] drain;

   assign drain      = req_tdata[136:105];
   assign req_tready = !q_full;

   assign qctl_push.push = req_tvalid && !q_full;
   assign qctl_push.full = q_full;

   always_comb begin
      q_entry.mode            = mode_type'(req_tuser);
      // zero or negative drain requests give no drain at all
      q_entry.drain_pos       = !drain[DRAIN_W-1] && (drain != '0);
      q_entry.frame_count     = req_tdata[15:0];
      q_entry.peak_level      = req_tdata[39:16];
      q_entry.peak_not_finite = req_tdata[40];
      q_entry.playing         = req_tdata[41];
      q_entry.play_position   = req_tdata[104:42];
      q_entry.drain_frames    = drain;
   end

endmodule

/* rtl/tdqd_queue.sv */
// ----------------------------------------------------------------------------
// tdqd_queue
// Short FIFO of classified requests between the front and the back.
// ----------------------------------------------------------------------------
module tdqd_queue #(
   parameter int Depth = tdqd_pkg::QUEUE_DEPTH
) (
   input  logic                 clock,
   input  logic                 reset,
   input  tdqd_pkg::qctl_type   qctl_push,
   input  tdqd_pkg::entry_type  push_entry,
   output logic                 full,
   input  logic                 pop,
   output logic                 head_valid,
   output tdqd_pkg::entry_type  head_entry
);
   import tdqd_pkg::*;

   localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;
   localparam int CntW = $clog2(Depth + 1);

   entry_type          slot_ff [Depth];
   logic [PtrW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PtrW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CntW-1:0]    count_ff,  count_in;
   logic               do_push, do_pop;

   assign full       = (count_ff == CntW'(Depth));
   assign head_valid = (count_ff != '0);
   assign head_entry = slot_ff[rd_ptr_ff];
   assign do_push    = qctl_push.push && !qctl_push.full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PtrW'(Depth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PtrW'(Depth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         slot_ff[wr_ptr_ff] <= push_entry;
      end
   end

endmodule

/* rtl/tdqd_back.sv */
// ----------------------------------------------------------------------------
// tdqd_back
// Execution side: holds the registers and detector state, rounds the drain
// request with a one-bit-per-cycle remainder unit, drives the response.
// ----------------------------------------------------------------------------
module tdqd_back (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               csr_we,
   input  logic [tdqd_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [tdqd_pkg::CSR_DATA_W-1:0]    csr_wdata,
   input  logic                               q_valid,
   input  tdqd_pkg::entry_type                q_entry,
   output logic                               q_pop,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   output logic [tdqd_pkg::RSP_DATA_W-1:0]    rsp_tdata
);
   import tdqd_pkg::*;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIV,
      ST_EXEC
   } state_type;

   state_type            state_ff, state_in;
   entry_type            work_ff, work_in;
   logic [DRAIN_W-1:0]   num_ff, num_in;
   logic [DRAIN_W-1:0]   shift_ff, shift_in;
   logic [BUFF_W-1:0]    rem_ff, rem_in;
   logic [STEP_W-1:0]    step_ff, step_in;

   logic [BUFF_W-1:0]    buffer_frames_ff;
   logic [RATE_W-1:0]    sample_rate_ff;
   logic [THR_W-1:0]     threshold_ff;

   logic                 drain_on_ff, drain_on_in;
   logic [LEFT_W-1:0]    drain_left_ff, drain_left_in;
   logic [SILENT_W-1:0]  silent_ff, silent_in;
   logic                 armed_ff, armed_in;
   logic                 quiet_ff, quiet_in;
   logic                 mute_ff, mute_in;
   logic [POS_W-1:0]     render_ff, render_in;

   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 event_ff, event_in;
   logic                 mute_out_ff, mute_out_in;

   logic [BUFF_W-1:0]    quantum;

   assign quantum = (buffer_frames_ff == '0) ? BUFF_W'(1) : buffer_frames_ff;

   always_comb begin
      logic [DRAIN_W-1:0]  num;
      logic [BUFF_W:0]     trial;
      logic [DRAIN_W-1:0]  aligned;
      logic [SILENT_W:0]   sum;
      logic [SILENT_W-1:0] sat;
      logic [NEED_W-1:0]   need;

      num     = {1'b0, q_entry.drain_frames[DRAIN_W-2:0]}
                + {{(DRAIN_W-BUFF_W){1'b0}}, quantum} - DRAIN_W'(1);
      trial   = {rem_ff, shift_ff[DRAIN_W-1]};
      aligned = num_ff - {{(DRAIN_W-BUFF_W){1'b0}}, rem_ff};
      sum     = {1'b0, silent_ff} + {{(SILENT_W-FRAMES_W+1){1'b0}}, work_ff.frame_count};
      sat     = sum[SILENT_W] ? '1 : sum[SILENT_W-1:0];
      need    = (sample_rate_ff[RATE_W-1:2] == '0) ? NEED_W'(1)
                                                   : sample_rate_ff[RATE_W-1:2];

      state_in      = state_ff;
      work_in       = work_ff;
      num_in        = num_ff;
      shift_in      = shift_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      drain_on_in   = drain_on_ff;
      drain_left_in = drain_left_ff;
      silent_in     = silent_ff;
      armed_in      = armed_ff;
      quiet_in      = quiet_ff;
      mute_in       = mute_ff;
      render_in     = render_ff;
      event_in      = event_ff;
      mute_out_in   = mute_out_ff;
      q_pop         = 1'b0;
      rsp_valid_in  = rsp_valid_ff && !rsp_tready;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop   = 1'b1;
               work_in = q_entry;
               if (q_entry.mode == MODE_STOP && q_entry.drain_pos) begin
                  num_in   = num;
                  shift_in = num;
                  rem_in   = '0;
                  step_in  = '0;
                  state_in = ST_DIV;
               end else begin
                  state_in = ST_EXEC;
               end
            end
         end
         ST_DIV: begin
            // restoring remainder, one numerator bit per cycle
            if (trial >= {1'b0, quantum}) begin
               rem_in = BUFF_W'(trial - {1'b0, quantum});
            end else begin
               rem_in = trial[BUFF_W-1:0];
            end
            shift_in = {shift_ff[DRAIN_W-2:0], 1'b0};
            step_in  = step_ff + 1'b1;
            if (step_ff == STEP_W'(DRAIN_W - 1)) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            if (!rsp_valid_ff || rsp_tready) begin
               event_in     = 1'b0;
               rsp_valid_in = 1'b1;
               state_in     = ST_IDLE;
               case (work_ff.mode)
                  MODE_BLOCK: begin
                     if (drain_on_ff) begin
                        if ({{(LEFT_W-FRAMES_W){1'b0}}, work_ff.frame_count}
                            >= drain_left_ff) begin
                           drain_on_in   = 1'b0;
                           drain_left_in = '0;
                           render_in     = work_ff.play_position;
                        end else begin
                           drain_left_in = drain_left_ff
                              - {{(LEFT_W-FRAMES_W){1'b0}}, work_ff.frame_count};
                           render_in     = render_ff
                              + {{(POS_W-FRAMES_W){1'b0}}, work_ff.frame_count};
                        end
                     end
                     if (work_ff.playing || !armed_ff || drain_on_in) begin
                        silent_in = '0;
                     end else if (work_ff.peak_not_finite
                                  || work_ff.peak_level > threshold_ff) begin
                        silent_in = '0;
                     end else begin
                        silent_in = sat;
                        if (sat >= {{(SILENT_W-NEED_W){1'b0}}, need}) begin
                           armed_in = 1'b0;
                           quiet_in = 1'b1;
                           event_in = 1'b1;
                        end
                     end
                  end
                  MODE_START: begin
                     drain_on_in   = 1'b0;
                     drain_left_in = '0;
                     armed_in      = 1'b0;
                     silent_in     = '0;
                     quiet_in      = 1'b0;
                     mute_in       = 1'b0;
                  end
                  MODE_STOP: begin
                     quiet_in  = 1'b0;
                     silent_in = '0;
                     armed_in  = 1'b1;
                     if (work_ff.drain_pos) begin
                        drain_left_in = {{(LEFT_W-DRAIN_W){1'b0}}, aligned};
                        drain_on_in   = 1'b1;
                     end else begin
                        drain_left_in = '0;
                        drain_on_in   = 1'b0;
                        render_in     = work_ff.play_position;
                     end
                  end
                  MODE_HOLD: begin
                     mute_in = 1'b1;
                  end
                  default: begin
                     mute_in = mute_ff;
                  end
               endcase
               mute_out_in = mute_in && !work_ff.playing;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_IDLE;
         buffer_frames_ff <= BUFFER_FRAMES_RST;
         sample_rate_ff   <= SAMPLE_RATE_RST;
         threshold_ff     <= SILENCE_THRESHOLD_RST;
         drain_on_ff      <= 1'b0;
         drain_left_ff    <= '0;
         silent_ff        <= '0;
         armed_ff         <= 1'b0;
         quiet_ff         <= 1'b0;
         mute_ff          <= 1'b0;
         render_ff        <= '0;
         rsp_valid_ff     <= 1'b0;
         event_ff         <= 1'b0;
         mute_out_ff      <= 1'b0;
      end else begin
         state_ff      <= state_in;
         drain_on_ff   <= drain_on_in;
         drain_left_ff <= drain_left_in;
         silent_ff     <= silent_in;
         armed_ff      <= armed_in;
         quiet_ff      <= quiet_in;
         mute_ff       <= mute_in;
         render_ff     <= render_in;
         rsp_valid_ff  <= rsp_valid_in;
         event_ff      <= event_in;
         mute_out_ff   <= mute_out_in;
         if (csr_we) begin
            case (csr_index)
               CSR_BUFFER_FRAMES:     buffer_frames_ff <= csr_wdata[BUFF_W-1:0];
               CSR_SAMPLE_RATE:       sample_rate_ff   <= csr_wdata[RATE_W-1:0];
               CSR_SILENCE_THRESHOLD: threshold_ff     <= csr_wdata[THR_W-1:0];
               default: begin
                  threshold_ff <= threshold_ff;
               end
            endcase
         end
      end
      work_ff  <= work_in;
      num_ff   <= num_in;
      shift_ff <= shift_in;
      rem_ff   <= rem_in;
      step_ff  <= step_in;
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {{(RSP_DATA_W-POS_W-4){1'b0}}, render_ff, mute_out_ff,
                        drain_on_ff, event_ff, quiet_ff};

endmodule

/* rtl/tdqd_checker.sv */
// ----------------------------------------------------------------------------
// tdqd_checker
// Port-level checks for the tail drain / quiet detector.
// ----------------------------------------------------------------------------
module tdqd_checker (
   input logic                               clock,
   input logic                               reset,
   input logic                               req_tvalid,
   input logic                               req_tready,
   input logic [tdqd_pkg::REQ_DATA_W-1:0]    req_tdata,
   input logic [1:0]                         req_tuser,
   input logic                               rsp_tvalid,
   input logic                               rsp_tready,
   input logic [tdqd_pkg::RSP_DATA_W-1:0]    rsp_tdata,
   input logic                               csr_we,
   input logic [tdqd_pkg::CSR_IDX_W-1:0]     csr_index,
   input logic [tdqd_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   // a stalled response stays up
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid)
      else $error("response dropped while stalled");

   a_rsp_reset: assert property (@(posedge clock)
      reset |=> !rsp_tvalid)
      else $error("response valid right after reset");

   // the event only comes with the quiet flag
   a_event_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[1] |-> rsp_tdata[0])
      else $error("quiet event without quiet flag");

   // quiet can only be reached once the drain is over
   a_busy_not_quiet: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[2] |-> !rsp_tdata[0])
      else $error("quiet while drain still running");

endmodule

bind tail_drain_quiet_detector tdqd_checker u_tdqd_checker (.*);

/* test/tdqd_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tdqd_status_checker
// Watches the request, status and register ports of the tail drain / quiet
// detector. It keeps its own copy of the drain, silence and mute state,
// predicts the status of every accepted request, and compares each returned
// status field by field with the oldest prediction.
// ----------------------------------------------------------------------------
module tdqd_status_checker (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   input  logic                            req_tready,
   input  logic [tdqd_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   input  logic [tdqd_pkg::RSP_DATA_W-1:0] rsp_tdata,
   input  logic                            csr_we,
   input  logic [tdqd_pkg::CSR_IDX_W-1:0]  csr_index,
   input  logic [tdqd_pkg::CSR_DATA_W-1:0] csr_wdata,
   output int                              fail_count,
   output int                              pending
);
   import tdqd_pkg::*;

   typedef struct {
      mode_type            mode;
      logic [FRAMES_W-1:0] frames;
      logic [PEAK_W-1:0]   peak;
      logic                not_finite;
      logic                playing;
      logic [POS_W-1:0]    play_pos;
      logic [DRAIN_W-1:0]  drain;
   } transport_req_type;

   typedef struct {
      logic             quiet;
      logic             fired;
      logic             draining;
      logic             muted;
      logic [POS_W-1:0] render;
   } transport_status_type;

   // register copies
   logic [BUFF_W-1:0]   quantum_q;
   logic [RATE_W-1:0]   rate_q;
   logic [THR_W-1:0]    threshold_q;

   // detector state
   logic                drain_on_q;
   logic [LEFT_W-1:0]   drain_left_q;
   logic [SILENT_W-1:0] silent_q;
   logic                armed_q;
   logic                quiet_q;
   logic                mute_q;
   logic [POS_W-1:0]    render_q;

   transport_status_type expected_status[$];
   int status_index;

   function automatic transport_status_type predict_status(input transport_req_type r);
      transport_status_type s;
      logic [63:0] quantum;
      logic [63:0] raw;
      logic [63:0] aligned;
      logic [63:0] need;
      logic [63:0] sum;
      logic        fired;
      fired = 1'b0;
      case (r.mode)
         MODE_BLOCK: begin
            if (drain_on_q) begin
               render_q = render_q + POS_W'(r.frames);
               if (LEFT_W'(r.frames) >= drain_left_q) begin
                  // drain finished: snap to the playback position
                  drain_on_q   = 1'b0;
                  drain_left_q = '0;
                  render_q     = r.play_pos;
               end else begin
                  drain_left_q = drain_left_q - LEFT_W'(r.frames);
               end
            end
            if (r.playing || !armed_q || drain_on_q) begin
               silent_q = '0;
            end else if (r.not_finite || r.peak > threshold_q) begin
               silent_q = '0;
            end else begin
               need = 64'(rate_q >> 2);
               if (need == 0) need = 64'd1;
               sum = 64'(silent_q) + 64'(r.frames);
               silent_q = (sum > 64'hFFFF_FFFF) ? '1 : sum[SILENT_W-1:0];
               if (64'(silent_q) >= need) begin
                  armed_q = 1'b0;
                  quiet_q = 1'b1;
                  fired   = 1'b1;
               end
            end
         end
         MODE_START: begin
            drain_on_q   = 1'b0;
            drain_left_q = '0;
            armed_q      = 1'b0;
            silent_q     = '0;
            quiet_q      = 1'b0;
            mute_q       = 1'b0;
         end
         MODE_STOP: begin
            raw     = 64'(r.drain);
            quantum = (quantum_q == 0) ? 64'd1 : 64'(quantum_q);
            // zero or negative request gives no drain
            if (raw[DRAIN_W-1] || raw == 0) aligned = '0;
            else aligned = ((raw + quantum - 1) / quantum) * quantum;
            quiet_q      = 1'b0;
            silent_q     = '0;
            armed_q      = 1'b1;
            drain_left_q = aligned[LEFT_W-1:0];
            drain_on_q   = (aligned != 0);
            if (aligned == 0) render_q = r.play_pos;
         end
         default: begin
            mute_q = 1'b1;
         end
      endcase
      s.quiet    = quiet_q;
      s.fired    = fired;
      s.draining = drain_on_q;
      s.muted    = mute_q && !r.playing;
      s.render   = render_q;
      return s;
   endfunction

   task automatic check_field(input string field, input logic [POS_W-1:0] want,
                              input logic [POS_W-1:0] got);
      if (want !== got) begin
         fail_count++;
         if (fail_count <= 10)
            $display("status %0d %s: expected %0h, got %0h", status_index, field, want, got);
      end
   endtask

   always @(posedge clock) begin : watch
      transport_req_type    seen;
      transport_status_type want;
      transport_status_type got;
      if (reset) begin
         quantum_q    = BUFFER_FRAMES_RST;
         rate_q       = SAMPLE_RATE_RST;
         threshold_q  = SILENCE_THRESHOLD_RST;
         drain_on_q   = 1'b0;
         drain_left_q = '0;
         silent_q     = '0;
         armed_q      = 1'b0;
         quiet_q      = 1'b0;
         mute_q       = 1'b0;
         render_q     = '0;
         expected_status.delete();
      end else begin
         if (csr_we) begin
            case (csr_index_type'(csr_index))
               CSR_BUFFER_FRAMES:     quantum_q   = csr_wdata[BUFF_W-1:0];
               CSR_SAMPLE_RATE:       rate_q      = csr_wdata[RATE_W-1:0];
               CSR_SILENCE_THRESHOLD: threshold_q = csr_wdata[THR_W-1:0];
               default: ;
            endcase
         end
         if (req_tvalid && req_tready) begin
            seen.mode       = mode_type'(req_tuser);
            seen.frames     = req_tdata[15:0];
            seen.peak       = req_tdata[39:16];
            seen.not_finite = req_tdata[40];
            seen.playing    = req_tdata[41];
            seen.play_pos   = req_tdata[104:42];
            seen.drain      = req_tdata[136:105];
            expected_status = {expected_status, predict_status(seen)};
         end
         if (rsp_tvalid && rsp_tready) begin
            got.quiet    = rsp_tdata[0];
            got.fired    = rsp_tdata[1];
            got.draining = rsp_tdata[2];
            got.muted    = rsp_tdata[3];
            got.render   = rsp_tdata[66:4];
            if (expected_status.size() == 0) begin
               fail_count++;
               if (fail_count <= 10)
                  $display("status %0d: no request waiting, got %0h", status_index, rsp_tdata);
            end else begin
               want = expected_status.pop_front();
               check_field("transport_quiet", POS_W'(want.quiet), POS_W'(got.quiet));
               check_field("quiet_event", POS_W'(want.fired), POS_W'(got.fired));
               check_field("drain_busy", POS_W'(want.draining), POS_W'(got.draining));
               check_field("mute_output", POS_W'(want.muted), POS_W'(got.muted));
               check_field("render_position", want.render, got.render);
            end
            status_index++;
         end
      end
      pending = expected_status.size();
   end

endmodule

/* test/tb.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// Stimulus for the tail drain / quiet detector: a directed pass over drain
// rounding, render wrap, silence counting and muting, then random stop/audio
// sequences under several register settings, with random stalls on both sides.
// ----------------------------------------------------------------------------
module tb;
   import tdqd_pkg::*;

   localparam int STALL_LIMIT = 4000;
   localparam logic [POS_W-1:0] POS_MAX = '1;

   logic                  clock;
   logic                  reset;
   logic                  req_tvalid;
   logic                  req_tready;
   // frame_count[15:0], peak_level[39:16], peak_not_finite[40], playing[41],
   // play_position[104:42], drain_frames[136:105]
   logic [REQ_DATA_W-1:0] req_tdata;
   // mode[1:0]
   logic [1:0]            req_tuser;
   logic                  rsp_tvalid;
   logic                  rsp_tready;
   // transport_quiet[0], quiet_event[1], drain_busy[2], mute_output[3],
   // render_position[66:4]
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   int fail_count;
   int pending;
   int stuck_cycles;
   int status_seen;
   int sender_steady;
   logic [THR_W-1:0] threshold_now;

   tail_drain_quiet_detector uut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   tdqd_status_checker status_check (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata),
      .fail_count (fail_count),
      .pending    (pending)
   );

   initial begin
      clock = 1'b0;
      forever #1 clock = ~clock;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (r < 50) return 0;
      if (r < 88) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 12);
      return $urandom_range(20, 60);
   endfunction

   function automatic logic [POS_W-1:0] any_position();
      return POS_W'({$urandom, $urandom});
   endfunction

   task automatic send_req(input mode_type m, input logic [FRAMES_W-1:0] frames,
                           input logic [PEAK_W-1:0] peak, input logic not_finite,
                           input logic playing, input logic [POS_W-1:0] pos,
                           input logic [DRAIN_W-1:0] drain);
      int gap;
      if (sender_steady > 0) begin
         gap = 0;
         sender_steady--;
      end else begin
         gap = pick_gap();
         if ($urandom_range(0, 39) == 0) sender_steady = $urandom_range(20, 80);
      end
      @(negedge clock);
      if (gap > 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser  <= m;
      req_tdata  <= {7'd0, drain, pos, playing, not_finite, peak, frames};
      do @(posedge clock); while (!req_tready);
   endtask

   // sender goes quiet until every status is back
   task automatic wait_status_drained();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (pending != 0) @(negedge clock);
      repeat (8) @(negedge clock);
   endtask

   task automatic load_config(input logic [BUFF_W-1:0] quantum,
                              input logic [RATE_W-1:0] rate,
                              input logic [THR_W-1:0] threshold);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_index <= CSR_BUFFER_FRAMES;
      csr_wdata <= CSR_DATA_W'(quantum);
      @(negedge clock);
      csr_index <= CSR_SAMPLE_RATE;
      csr_wdata <= CSR_DATA_W'(rate);
      @(negedge clock);
      csr_index <= CSR_SILENCE_THRESHOLD;
      csr_wdata <= threshold;
      @(negedge clock);
      csr_we <= 1'b0;
      threshold_now = threshold;
   endtask

   // stop requests followed by runs of audio blocks, with some noise mixed in
   task automatic run_random(input int count);
      int sent;
      int r;
      logic [FRAMES_W-1:0] frames;
      logic [PEAK_W-1:0]   peak;
      logic [DRAIN_W-1:0]  drain;
      mode_type            m;
      sent = 0;
      while (sent < count) begin
         if ($urandom_range(0, 99) < 15) begin
            m = mode_type'($urandom_range(0, 3));
            send_req(m, FRAMES_W'($urandom), PEAK_W'($urandom), 1'($urandom),
                     1'($urandom), any_position(), $urandom);
            sent++;
         end else begin
            r = $urandom_range(0, 99);
            if (r < 10) drain = '0;
            else if (r < 20) drain = $urandom | 32'h8000_0000;
            else if (r < 25) drain = 32'h7FFF_FFFF;
            else if (r < 30) drain = $urandom;
            else drain = $urandom_range(1, 20000);
            send_req(MODE_STOP, FRAMES_W'($urandom), PEAK_W'($urandom), 1'($urandom),
                     1'($urandom), any_position(), drain);
            sent++;
            repeat ($urandom_range(3, 24)) begin
               r = $urandom_range(0, 99);
               if (r < 4) m = MODE_HOLD;
               else if (r < 7) m = MODE_START;
               else m = MODE_BLOCK;
               r = $urandom_range(0, 99);
               if (r < 25) frames = FRAMES_W'($urandom_range(0, 63));
               else if (r < 70) frames = FRAMES_W'($urandom_range(64, 4095));
               else if (r < 92) frames = FRAMES_W'($urandom_range(4096, 65535));
               else if (r < 96) frames = '0;
               else frames = '1;
               r = $urandom_range(0, 99);
               if (r < 80 || threshold_now == '1)
                  peak = PEAK_W'($urandom_range(0, threshold_now));
               else if (r < 95)
                  peak = PEAK_W'($urandom_range(32'(threshold_now) + 1, 24'hFF_FFFF));
               else peak = PEAK_W'($urandom);
               send_req(m, frames, peak, $urandom_range(0, 19) == 0,
                        $urandom_range(0, 11) == 0, any_position(), $urandom);
               sent++;
            end
         end
      end
   endtask

   // handshake watchdog and status counter
   always @(posedge clock) begin
      if (reset) begin
         stuck_cycles <= 0;
      end else if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready)) begin
         stuck_cycles <= 0;
      end else begin
         stuck_cycles <= stuck_cycles + 1;
      end
      if (!reset && rsp_tvalid && rsp_tready) status_seen <= status_seen + 1;
      if (stuck_cycles >= STALL_LIMIT) begin
         $display("simulation failed");
         $finish;
      end
   end

   // status receiver: random stalls, one long hold to back up the request side
   initial begin : receiver
      int stall;
      int steady;
      bit long_hold_done;
      rsp_tready = 1'b0;
      steady = 0;
      long_hold_done = 1'b0;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         if (!long_hold_done && status_seen >= 400) begin
            long_hold_done = 1'b1;
            stall = 300;
         end else if (steady > 0) begin
            steady--;
            stall = 0;
         end else begin
            stall = pick_gap();
            if ($urandom_range(0, 49) == 0) steady = $urandom_range(30, 120);
         end
         if (stall > 0) begin
            rsp_tready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         @(negedge clock);
      end
   end

   initial begin : stimulus
      int phase;
      reset         = 1'b1;
      req_tvalid    = 1'b0;
      req_tdata     = '0;
      req_tuser     = MODE_BLOCK;
      csr_we        = 1'b0;
      csr_index     = CSR_BUFFER_FRAMES;
      csr_wdata     = '0;
      sender_steady = 0;
      threshold_now = SILENCE_THRESHOLD_RST;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed pass, reset register values (need 12000 frames, threshold 7)
      send_req(MODE_BLOCK, '0, '0, 1'b0, 1'b0, '0, '0);
      send_req(MODE_HOLD, '0, '0, 1'b0, 1'b0, '0, '0);
      send_req(MODE_BLOCK, '1, '1, 1'b1, 1'b1, '0, '0);       // playing hides mute
      send_req(MODE_START, '0, '0, 1'b0, 1'b0, '0, '0);
      send_req(MODE_STOP, '0, '0, 1'b0, 1'b0, POS_MAX, '0);   // no drain, snap
      send_req(MODE_BLOCK, '1, 24'd7, 1'b0, 1'b0, '0, '0);    // peak at threshold
      send_req(MODE_BLOCK, '1, '0, 1'b0, 1'b0, '0, '0);       // already fired
      send_req(MODE_STOP, '0, '0, 1'b0, 1'b0, 63'd5, 32'h8000_0000);
      send_req(MODE_BLOCK, 16'd6000, 24'd8, 1'b0, 1'b0, '0, '0);
      send_req(MODE_BLOCK, 16'd6000, '0, 1'b1, 1'b0, '0, '0);
      send_req(MODE_BLOCK, 16'd11999, '0, 1'b0, 1'b0, '0, '0);
      send_req(MODE_BLOCK, 16'd1, '0, 1'b0, 1'b0, '0, '0);    // reaches the need
      send_req(MODE_STOP, '0, '0, 1'b0, 1'b0, POS_MAX, '0);
      send_req(MODE_STOP, '0, '0, 1'b0, 1'b0, '0, 32'd1);     // rounds up to 512
      send_req(MODE_BLOCK, 16'd100, '0, 1'b0, 1'b0, '0, '0);  // render wraps
      send_req(MODE_BLOCK, '0, '0, 1'b0, 1'b0, '0, '0);       // empty block
      send_req(MODE_BLOCK, 16'd412, '0, 1'b0, 1'b0, 63'd777, '0);
      send_req(MODE_STOP, '0, '0, 1'b0, 1'b0, '0, 32'h7FFF_FFFF);
      send_req(MODE_HOLD, '0, '0, 1'b0, 1'b0, '0, '0);
      send_req(MODE_BLOCK, '1, '0, 1'b0, 1'b1, POS_MAX, '0);
      send_req(MODE_START, '1, '1, 1'b1, 1'b1, POS_MAX, '1);
      send_req(MODE_BLOCK, 16'd20000, '0, 1'b0, 1'b0, '0, '0); // not armed
      send_req(MODE_STOP, '0, '0, 1'b0, 1'b0, 63'd42, '1);
      wait_status_drained();

      for (phase = 0; phase < 7; phase++) begin
         case (phase)
            0: ;
            1: load_config('0, '0, '0);
            2: load_config(14'd8192, 19'd384000, 24'hFF_FFFF);
            3: load_config(14'd1, 19'd3, 24'd7);
            4: load_config(14'd8191, 19'd4, 24'd1);
            default: load_config(BUFF_W'($urandom_range(0, 8192)),
                                 RATE_W'($urandom_range(0, 384000)),
                                 THR_W'($urandom_range(0, 24'hFF_FFFF)));
         endcase
         run_random(280);
         wait_status_drained();
      end

      repeat (40) @(negedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
